/* hdl/regular_shape_mesh_index_gen_core_defines.svh */
// Assertion macros for the regular shape mesh index generator
`ifndef REGULAR_SHAPE_MESH_INDEX_GEN_CORE_DEFINES_SVH
`define REGULAR_SHAPE_MESH_INDEX_GEN_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled at the rising clock edge
`define RSMIG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsmig: same-cycle check failed");
// next-cycle implication
`define RSMIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsmig: next-cycle check failed");
`else
`define RSMIG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RSMIG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/rsmig_pkg.sv */
// Shared types, constants and helpers of the mesh index generator
`timescale 1ns / 1ps

package rsmig_pkg;

    localparam int MAX_SIDES = 64;

    localparam int W_KIND   = 2;
    localparam int W_SIDES  = 7;
    localparam int W_SLOT   = 10;
    localparam int W_VERTEX = 9;
    localparam int W_LENGTH = 10;

    // fan levels with stride 2^j, active while 2^(j+1) < n
    localparam int LEVELS = $clog2(MAX_SIDES) - 1;

    localparam logic [W_SIDES:0] SIDES_MIN = (W_SIDES + 1)'(3);
    localparam logic [W_SIDES:0] SIDES_MAX = MAX_SIDES[W_SIDES:0];

    // floor(d / 3) = (d * 683) >> 11, exact for d below 2048
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef enum logic [W_KIND-1:0] {
        KIND_POLYGON = 2'd0,
        KIND_PRISM   = 2'd1,
        KIND_PYRAMID = 2'd2
    } shape_kind_t;

    typedef struct packed {
        logic [W_KIND-1:0]  req_type;
        logic               split_faces;
        logic [W_SIDES-1:0] num_sides;
        logic [W_SLOT-1:0]  slot;
    } req_t;

    typedef struct packed {
        logic [W_VERTEX-1:0] vertex_index;
        logic                slot_valid;
        logic                is_last_slot;
        logic [W_LENGTH-1:0] list_length;
    } res_t;

    function automatic logic [W_SLOT-1:0] div3(input logic [W_SLOT-1:0] d);
        logic [W_SLOT+DIV3_SHIFT-1:0] prod;
        prod = (W_SLOT + DIV3_SHIFT)'(d) * (W_SLOT + DIV3_SHIFT)'(DIV3_MUL);
        return prod[W_SLOT+DIV3_SHIFT-1:DIV3_SHIFT];
    endfunction

endpackage

/* hdl/rsmig_index_calc.sv */
// Slot decode: list length, fan cap lookup and side entry numbering
`timescale 1ns / 1ps

module rsmig_index_calc
    import rsmig_pkg::*;
(
    input  req_t req,
    output res_t res
);

    logic [W_SIDES:0]    n8;
    logic [W_LENGTH-1:0] n_l;
    logic [W_LENGTH-1:0] n3;
    logic [W_LENGTH-1:0] cap;
    logic [W_LENGTH-1:0] cap2;
    logic [W_LENGTH-1:0] len;
    logic [W_LENGTH-1:0] slot_l;
    logic                n_ok;
    logic                is_prism;
    logic                in_cap;
    logic                in_top;
    logic                valid;
    logic [W_SLOT-1:0]   d;
    logic [W_SLOT-1:0]   q;
    logic [W_SLOT-1:0]   rem_full;
    logic [1:0]          rem;
    logic [W_SIDES:0]    tri_idx;
    logic [W_SIDES:0]    start_j;
    logic [W_SIDES:0]    base_i;
    logic [W_SIDES:0]    stride;
    logic [W_SIDES:0]    c2;
    logic [W_LENGTH-1:0] base_v;
    logic [W_LENGTH-1:0] side_i;
    logic [W_LENGTH-1:0] side_nx;
    logic [2:0]          entry;
    logic [W_LENGTH-1:0] vtx;

    assign n8       = {1'b0, req.num_sides};
    assign n_l      = W_LENGTH'(req.num_sides);
    assign n3       = (n_l << 1) + n_l;
    assign cap      = n3 - W_LENGTH'(6);
    assign cap2     = cap << 1;
    assign n_ok     = (n8 >= SIDES_MIN) && (n8 <= SIDES_MAX);
    assign is_prism = (req.req_type == KIND_PRISM);
    assign slot_l   = W_LENGTH'(req.slot);

    always_comb
    begin
        len = '0;
        if (n_ok)
        begin
            unique case (req.req_type)
                KIND_POLYGON: len = cap;
                KIND_PRISM:   len = (n3 << 2) - W_LENGTH'(12);
                KIND_PYRAMID: len = (n3 << 1) - W_LENGTH'(6);
                default:      len = '0;
            endcase
        end
    end

    assign valid  = slot_l < len;
    assign in_cap = slot_l < cap;
    assign in_top = is_prism && (slot_l < cap2);

    // one divide-by-three serves the cap, the top cap and both side layouts
    always_comb
    begin
        if (in_cap)
            d = req.slot;
        else if (is_prism && !in_top)
            d = W_SLOT'(slot_l - cap2);
        else
            d = W_SLOT'(slot_l - cap);
    end

    assign q        = div3(d);
    assign rem_full = d - ((q << 1) + q);
    assign rem      = rem_full[1:0];
    assign tri_idx  = q[W_SIDES:0];

    // pick the fan level: levels before j hold n - ceil(n / 2^j) triangles
    always_comb
    begin
        base_i = '0;
        stride = (W_SIDES + 1)'(1);
        for (int j = 0; j < LEVELS; j++)
        begin
            start_j = n8 - ((n8 + (((W_SIDES + 1)'(1) << j) - (W_SIDES + 1)'(1))) >> j);
            if ((n8 > ((W_SIDES + 1)'(1) << (j + 1))) && (tri_idx >= start_j))
            begin
                base_i = (tri_idx - start_j) << (j + 1);
                stride = (W_SIDES + 1)'(1) << j;
            end
        end
    end

    // third corner wraps to vertex 0 past the last side
    assign c2 = ((base_i + (stride << 1)) >= n8) ? '0 : base_i + (stride << 1);

    always_comb
    begin
        case (rem)
            2'd0:    base_v = W_LENGTH'(base_i);
            2'd1:    base_v = W_LENGTH'(base_i + stride);
            default: base_v = W_LENGTH'(c2);
        endcase
    end

    // side number and entry within the side
    always_comb
    begin
        if (is_prism)
        begin
            side_i = W_LENGTH'(q >> 1);
            entry  = {1'b0, rem} + (q[0] ? 3'd3 : 3'd0);
        end
        else
        begin
            side_i = W_LENGTH'(q);
            entry  = {1'b0, rem};
        end
    end

    assign side_nx = ((side_i + W_LENGTH'(1)) == n_l) ? '0 : side_i + W_LENGTH'(1);

    always_comb
    begin
        vtx = '0;
        if (in_cap)
            vtx = base_v;
        else if (in_top)
            vtx = base_v + n_l;
        else if (is_prism)
        begin
            if (req.split_faces)
            begin
                case (entry) inside
                    3'd0:       vtx = (n_l << 1) + side_i;
                    3'd1:       vtx = (n_l << 2) + side_nx;
                    3'd2, 3'd3: vtx = n3 + side_i;
                    3'd4:       vtx = (n_l << 2) + n_l + side_nx;
                    default:    vtx = (n_l << 2) + side_nx;
                endcase
            end
            else
            begin
                case (entry) inside
                    3'd0:       vtx = side_i;
                    3'd1:       vtx = side_nx;
                    3'd2, 3'd3: vtx = n_l + side_i;
                    3'd4:       vtx = n_l + side_nx;
                    default:    vtx = side_nx;
                endcase
            end
        end
        else
        begin
            if (req.split_faces)
            begin
                case (entry)
                    3'd0:    vtx = n_l + side_i;
                    3'd1:    vtx = (n_l << 1) + side_nx;
                    default: vtx = n3 + side_i;
                endcase
            end
            else
            begin
                case (entry)
                    3'd0:    vtx = side_i;
                    3'd1:    vtx = side_nx;
                    default: vtx = n_l;
                endcase
            end
        end
    end

    assign res.vertex_index = valid ? W_VERTEX'(vtx) : '0;
    assign res.slot_valid   = valid;
    assign res.is_last_slot = valid && ((slot_l + W_LENGTH'(1)) == len);
    assign res.list_length  = len;

endmodule

/* hdl/regular_shape_mesh_index_gen_core.sv */
// Top level of the regular shape mesh index generator
//
//  channel   handshake          payload
//  -------   ----------------   -----------------------------------------------
//  request   start / busy       req_type, split_faces, num_sides, slot
//  result    done (strobe)      vertex_index, slot_valid, is_last_slot, list_length
//
// One item per cycle. Each result passes through the input register and then
// the result register, around one decode pass (divide-by-three multiply, fan
// level select, entry mux).
// busy is never raised: the block takes a new item on every cycle.
// Reset clears the valid pipeline only; results are not held off by the receiver.
`timescale 1ns / 1ps
`include "regular_shape_mesh_index_gen_core_defines.svh"

module regular_shape_mesh_index_gen_core
    import rsmig_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [W_KIND-1:0]   req_type,
    input  logic                split_faces,
    input  logic [W_SIDES-1:0]  num_sides,
    input  logic [W_SLOT-1:0]   slot,
    output logic                done,
    output logic [W_VERTEX-1:0] vertex_index,
    output logic                slot_valid,
    output logic                is_last_slot,
    output logic [W_LENGTH-1:0] list_length
);

    logic in_valid_reg;
    logic done_reg;
    req_t req_next;
    req_t req_reg;
    res_t res_next;
    res_t res_reg;

    assign busy = 1'b0;

    assign req_next.req_type    = req_type;
    assign req_next.split_faces = split_faces;
    assign req_next.num_sides   = num_sides;
    assign req_next.slot        = slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    // hold the item until the decode result is captured
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            req_reg <= req_next;
        if (in_valid_reg)
            res_reg <= res_next;
    end

    rsmig_index_calc u_calc (
        .req (req_reg),
        .res (res_next)
    );

    assign done         = done_reg;
    assign vertex_index = res_reg.vertex_index;
    assign slot_valid   = res_reg.slot_valid;
    assign is_last_slot = res_reg.is_last_slot;
    assign list_length  = res_reg.list_length;

    `RSMIG_ASSERT_NEXT(a_start_to_stage, clk, rst_n, start && !busy, in_valid_reg)
    `RSMIG_ASSERT_IMPLY(a_done_from_start, clk, rst_n, done, $past(start && !busy, 2))
    `RSMIG_ASSERT_IMPLY(a_last_is_valid, clk, rst_n, done && is_last_slot, slot_valid)
    `RSMIG_ASSERT_IMPLY(a_invalid_zero, clk, rst_n, done && !slot_valid, vertex_index == '0)
    `RSMIG_ASSERT_IMPLY(a_valid_has_len, clk, rst_n, done && slot_valid, list_length != '0)

endmodule
